@@ rtl/core/rmm_pkg.sv @@
// shared constants and types of the range min/max tree
package rmm_pkg;

  // width of the leaf index fields on the input beat
  localparam int unsigned IDX_W = 10;

  // magnitude of the neutral pair: min side holds +1e10, max side -1e10
  localparam logic [63:0] NEUTRAL_POS = 64'd10000000000;

  // request kinds carried on the input tuser
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

endpackage

@@ rtl/core/rmm_mem.sv @@
// node memory: one write port, one read port with registered read data
module rmm_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 96,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/rmm_cmb.sv @@
// shared combine unit: signed min of the min halves, signed max of the max halves
module rmm_cmb #(
  parameter int unsigned WIDTH = 48
) (
  input  logic [WIDTH-1:0] a_min_i,
  input  logic [WIDTH-1:0] a_max_i,
  input  logic [WIDTH-1:0] b_min_i,
  input  logic [WIDTH-1:0] b_max_i,
  output logic [WIDTH-1:0] y_min_o,
  output logic [WIDTH-1:0] y_max_o
);

  assign y_min_o = ($signed(b_min_i) < $signed(a_min_i)) ? b_min_i : a_min_i;
  assign y_max_o = ($signed(a_max_i) < $signed(b_max_i)) ? b_max_i : a_max_i;

endmodule

@@ rtl/core/range_min_max_tree.sv @@
// range min/max tree: bottom-up segment tree with leaf writes and range queries
// write: the leaf and its path up to the root are rewritten before ready returns, no result
// query: walks the tree level by level to the result beat, paced by the one read port
//   of the node memory; at most one node read per cycle, up to two nodes per tree level
// one request at a time; a waiting result does not block the next accept
// reset: asynchronous; afterwards a clearing pass writes the neutral pair into all
//   2*LEAVES nodes while s_axis_tready stays low
module range_min_max_tree #(
  parameter int unsigned LEAVES      = 1024,
  parameter int unsigned VALUE_WIDTH = 48,
  localparam int unsigned IN_TW  = ((2 * rmm_pkg::IDX_W + VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_TW = ((2 * VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // left_index, right_index, leaf_value
  input  logic [IN_TW-1:0]  s_axis_tdata,
  // req_type
  input  logic              s_axis_tuser,
  // result channel
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // range_min, range_max
  output logic [OUT_TW-1:0] m_axis_tdata
);

  localparam int unsigned IW    = rmm_pkg::IDX_W;
  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned DEPTH = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);
  // cursor width: the exclusive right end of a query can reach 2*LEAVES
  localparam int unsigned CW    = AW + 1;

  localparam logic [VW-1:0] NEU_MIN = VW'(rmm_pkg::NEUTRAL_POS);
  localparam logic [VW-1:0] NEU_MAX = VW'(64'd0 - rmm_pkg::NEUTRAL_POS);

  typedef enum logic [2:0] {
    ST_CLR,    // clearing pass after reset
    ST_IDLE,   // ready for a request
    ST_UP,     // write walk toward the root
    ST_QRY,    // query walk, at most one node read per cycle
    ST_QLAST   // fold the last read and hand over the result
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [AW-1:0]   node_q, node_d;     // node rewritten next on the write walk
  logic [CW-1:0]   lcur_q, lcur_d;     // query left cursor (inclusive)
  logic [CW-1:0]   rcur_q, rcur_d;     // query right cursor (exclusive)
  logic [VW-1:0]   acc_min_q, acc_min_d;
  logic [VW-1:0]   acc_max_q, acc_max_d;
  logic            pend_q, pend_d;     // a node read lands in rdata this cycle
  logic            ovld_q, ovld_d;
  logic [VW-1:0]   omin_q, omin_d;
  logic [VW-1:0]   omax_q, omax_d;

  // memory port
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [2*VW-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [2*VW-1:0] mem_rdata;

  // combine unit
  logic [VW-1:0]   cmb_min, cmb_max;

  // request fields
  logic [IW-1:0]   lidx, ridx;
  logic [VW-1:0]   wval;
  logic [CW-1:0]   lclamp, rclamp;
  logic [AW-1:0]   leaf_addr;
  logic [CW-1:0]   lcur_inc, rcur_dec;

  assign lidx = s_axis_tdata[IW-1:0];
  assign ridx = s_axis_tdata[2*IW-1:IW];
  assign wval = s_axis_tdata[2*IW +: VW];

  // query ends are clamped to the last leaf
  assign lclamp = (32'(lidx) >= LEAVES) ? CW'(LEAVES - 1) : CW'(lidx);
  assign rclamp = (32'(ridx) >= LEAVES) ? CW'(LEAVES - 1) : CW'(ridx);
  // only used when the index is inside the leaf count
  assign leaf_addr = AW'(LEAVES) + AW'(lidx);

  assign lcur_inc = lcur_q + CW'(1);
  assign rcur_dec = rcur_q - CW'(1);

  rmm_mem #(
    .DEPTH (DEPTH),
    .WIDTH (2 * VW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // accumulator against the node just read; rows hold {max, min}
  rmm_cmb #(
    .WIDTH (VW)
  ) u_cmb (
    .a_min_i (acc_min_q),
    .a_max_i (acc_max_q),
    .b_min_i (mem_rdata[VW-1:0]),
    .b_max_i (mem_rdata[2*VW-1:VW]),
    .y_min_o (cmb_min),
    .y_max_o (cmb_max)
  );

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    node_d    = node_q;
    lcur_d    = lcur_q;
    rcur_d    = rcur_q;
    acc_min_d = acc_min_q;
    acc_max_d = acc_max_q;
    pend_d    = 1'b0;
    ovld_d    = ovld_q;
    omin_d    = omin_q;
    omax_d    = omax_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = {cmb_max, cmb_min};
    mem_re    = 1'b0;
    mem_raddr = '0;

    // result beat leaves
    if (ovld_q && m_axis_tready) begin
      ovld_d = 1'b0;
    end

    // fold any landed node read into the accumulator
    if (pend_q) begin
      acc_min_d = cmb_min;
      acc_max_d = cmb_max;
    end

    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {NEU_MAX, NEU_MIN};
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == rmm_pkg::REQ_WRITE) begin
            // writes beyond the leaf count are dropped
            if (32'(lidx) < LEAVES) begin
              mem_we    = 1'b1;
              mem_waddr = leaf_addr;
              mem_wdata = {wval, wval};
              acc_min_d = wval;
              acc_max_d = wval;
              if (leaf_addr != AW'(1)) begin
                mem_re    = 1'b1;
                mem_raddr = leaf_addr ^ AW'(1);
                pend_d    = 1'b1;
                node_d    = leaf_addr >> 1;
                state_d   = ST_UP;
              end
            end
          end else begin
            acc_min_d = NEU_MIN;
            acc_max_d = NEU_MAX;
            if (lclamp <= rclamp) begin
              lcur_d  = lclamp + CW'(LEAVES);
              rcur_d  = rclamp + CW'(LEAVES) + CW'(1);
              state_d = ST_QRY;
            end else begin
              // empty range: neutral pair
              state_d = ST_QLAST;
            end
          end
        end
      end

      ST_UP: begin
        // parent gets the path value combined with the sibling just read
        mem_we    = 1'b1;
        mem_waddr = node_q;
        if (node_q == AW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = node_q ^ AW'(1);
          pend_d    = 1'b1;
          node_d    = node_q >> 1;
        end
      end

      ST_QRY: begin
        if (lcur_q < rcur_q) begin
          if (lcur_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = lcur_q[AW-1:0];
            pend_d    = 1'b1;
            if (rcur_q[0]) begin
              // right edge still to take on this level
              lcur_d = lcur_inc;
            end else begin
              lcur_d = lcur_inc >> 1;
              rcur_d = rcur_q >> 1;
            end
          end else if (rcur_q[0]) begin
            mem_re    = 1'b1;
            mem_raddr = rcur_dec[AW-1:0];
            pend_d    = 1'b1;
            lcur_d    = lcur_q >> 1;
            rcur_d    = rcur_dec >> 1;
          end else begin
            lcur_d = lcur_q >> 1;
            rcur_d = rcur_q >> 1;
          end
        end else begin
          state_d = ST_QLAST;
        end
      end

      ST_QLAST: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d  = 1'b1;
          omin_d  = pend_q ? cmb_min : acc_min_q;
          omax_d  = pend_q ? cmb_max : acc_max_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_q     <= '0;
      node_q    <= '0;
      lcur_q    <= '0;
      rcur_q    <= '0;
      acc_min_q <= NEU_MIN;
      acc_max_q <= NEU_MAX;
      pend_q    <= 1'b0;
      ovld_q    <= 1'b0;
      omin_q    <= NEU_MIN;
      omax_q    <= NEU_MAX;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      node_q    <= node_d;
      lcur_q    <= lcur_d;
      rcur_q    <= rcur_d;
      acc_min_q <= acc_min_d;
      acc_max_q <= acc_max_d;
      pend_q    <= pend_d;
      ovld_q    <= ovld_d;
      omin_q    <= omin_d;
      omax_q    <= omax_d;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = OUT_TW'({omax_q, omin_q});

endmodule

@@ rtl/core/rmm_chk.sv @@
// port-level checker for the range min/max tree and its bind
module rmm_chk #(
  parameter int unsigned VALUE_WIDTH = 48,
  localparam int unsigned OUT_TW = ((2 * VALUE_WIDTH + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_TW-1:0] m_axis_tdata
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam logic [VW-1:0] NEU_MIN = VW'(rmm_pkg::NEUTRAL_POS);
  localparam logic [VW-1:0] NEU_MAX = VW'(64'd0 - rmm_pkg::NEUTRAL_POS);

  logic [VW-1:0] res_min, res_max;

  assign res_min = m_axis_tdata[VW-1:0];
  assign res_max = m_axis_tdata[2*VW-1:VW];

  // no result beat in the cycle after a reset edge
  a_no_beat_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result beat during reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // a query keeps the block busy for at least the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == rmm_pkg::REQ_QUERY)
    |=> !s_axis_tready)
    else $error("request taken right after a query beat");

  // a result is either the neutral pair or an ordered min/max pair
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((res_min == NEU_MIN) && (res_max == NEU_MAX)) ||
      ($signed(res_min) <= $signed(res_max)))
    else $error("result min above max");

endmodule

bind range_min_max_tree rmm_chk #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_rmm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
